// ===== rtl/sssu_pkg.sv =====
// ----------------------------------------------------------------------------
// sssu_pkg - shared types and constants of the syllable splitter
// Sonority levels, phone feature word, split-unit request, item and result
// words that travel between the sequencer and the top level.
// ----------------------------------------------------------------------------
package sssu_pkg;

    localparam int CLUSTER_DEPTH_DEF   = 8;
    localparam int PHONE_CODE_BITS_DEF = 8;
    localparam int PHONE_PORT_BITS     = 8;

    typedef logic [3:0] level_t;

    localparam level_t LV_PLOSIVE  = 4'd0;
    localparam level_t LV_FRIC     = 4'd1;
    localparam level_t LV_NASAL    = 4'd2;
    localparam level_t LV_LATERAL  = 4'd3;
    localparam level_t LV_STRIDENT = 4'd4;
    localparam level_t LV_VIBRANT  = 4'd5;
    localparam level_t LV_APPROX   = 4'd6;
    localparam level_t LV_VOWEL    = 4'd7;
    localparam level_t LV_UNKNOWN  = 4'd8;

    // vocalic sits in the lowest bit
    typedef struct packed {
        logic is_affricate;
        logic is_fricative;
        logic is_alveolar;
        logic is_strident;
        logic is_approximant;
        logic is_liquid;
        logic is_lateral;
        logic is_nasal;
        logic is_plosive;
        logic vocalic;
    } phone_feat_t;

    typedef struct packed {
        level_t lvl;
        level_t prev;
    } split_req_t;

    typedef struct packed {
        logic [PHONE_PORT_BITS-1:0] phone;
        level_t                     level;
        logic                       wend;
    } item_t;

    typedef struct packed {
        logic [PHONE_PORT_BITS-1:0] phone;
        logic                       start;
        logic                       last;
        logic                       ovf;
    } res_t;

    function automatic level_t level_of(input phone_feat_t f);
        level_t l;
        if (f.vocalic)
        begin
            l = LV_VOWEL;
        end
        else if (f.is_plosive)
        begin
            l = LV_PLOSIVE;
        end
        else if (f.is_nasal)
        begin
            l = LV_NASAL;
        end
        else if (f.is_lateral)
        begin
            l = LV_LATERAL;
        end
        else if (f.is_liquid)
        begin
            l = LV_VIBRANT;
        end
        else if (f.is_approximant)
        begin
            l = LV_APPROX;
        end
        else if (f.is_strident && f.is_alveolar)
        begin
            l = LV_STRIDENT;
        end
        else if (f.is_fricative || f.is_affricate)
        begin
            l = LV_FRIC;
        end
        else
        begin
            l = LV_UNKNOWN;
        end
        return l;
    endfunction

endpackage

// ===== rtl/sssu_cluster_mem.sv =====
// ----------------------------------------------------------------------------
// sssu_cluster_mem - consonant cluster store
// One write port and one registered read port; entries hold level and code.
// ----------------------------------------------------------------------------
module sssu_cluster_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/sssu_split_unit.sv =====
// ----------------------------------------------------------------------------
// sssu_split_unit - shared sonority compare
// Decides whether a backward step from prev to lvl marks a syllable boundary.
// ----------------------------------------------------------------------------
module sssu_split_unit (
    input  sssu_pkg::split_req_t req,
    output logic                 split
);

    import sssu_pkg::*;

    always_comb
    begin
        split = 1'b0;
        if (req.lvl > req.prev)
        begin
            split = 1'b1;
        end
        else if (req.lvl == req.prev && req.lvl != LV_APPROX)
        begin
            split = 1'b1;
        end
        // exception pairs that break despite falling sonority
        else if ((req.lvl == LV_PLOSIVE && req.prev == LV_NASAL)
              || (req.lvl == LV_NASAL && req.prev == LV_STRIDENT)
              || (req.lvl == LV_NASAL && req.prev == LV_LATERAL)
              || (req.lvl == LV_LATERAL && req.prev == LV_STRIDENT))
        begin
            split = 1'b1;
        end
    end

endmodule

// ===== rtl/sssu_seq.sv =====
// ----------------------------------------------------------------------------
// sssu_seq - cluster sequencer
// Buffers consonants in a circular store, walks it backward through the
// shared split unit when a vowel follows an earlier vowel of the word, then
// drains it word by word into the output register on a vowel or word end.
// ----------------------------------------------------------------------------
module sssu_seq #(
    parameter int CLUSTER_DEPTH   = 8,
    parameter int PHONE_CODE_BITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sssu_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output sssu_pkg::res_t  out_res
);

    import sssu_pkg::*;

    localparam int IDXW = $clog2(CLUSTER_DEPTH);
    localparam int CNTW = $clog2(CLUSTER_DEPTH + 1);
    localparam int MEMW = PHONE_CODE_BITS + 4;
    localparam logic [IDXW:0]   DEPTH_X   = (IDXW+1)'(CLUSTER_DEPTH);
    localparam logic [CNTW-1:0] CNT_DEPTH = CNTW'(CLUSTER_DEPTH);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PRIME     = 4'd1;
    localparam logic [3:0] S_WALK      = 4'd2;
    localparam logic [3:0] S_WEND      = 4'd3;
    localparam logic [3:0] S_EMIT_RD   = 4'd4;
    localparam logic [3:0] S_EMIT_OUT  = 4'd5;
    localparam logic [3:0] S_EMIT_LAST = 4'd6;
    localparam logic [3:0] S_OVF_RD    = 4'd7;
    localparam logic [3:0] S_OVF_OUT   = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic [CNTW-1:0]            count_reg, count_next;
    logic [IDXW-1:0]            head_reg, head_next;
    logic                       vowel_seen_reg, vowel_seen_next;
    logic                       start_pending_reg, start_pending_next;
    logic [IDXW-1:0]            j_reg, j_next;
    logic [CNTW-1:0]            i_reg, i_next;
    level_t                     prev_reg, prev_next;
    logic                       mark_valid_reg, mark_valid_next;
    logic [IDXW-1:0]            mark_idx_reg, mark_idx_next;
    logic [PHONE_CODE_BITS-1:0] code_hold_reg, code_hold_next;
    level_t                     lvl_hold_reg, lvl_hold_next;
    logic                       wend_hold_reg, wend_hold_next;
    logic                       vstart_hold_reg, vstart_hold_next;
    logic                       out_valid_reg, out_valid_next;
    res_t                       res_reg, res_next;

    logic                       wr_en, rd_en;
    logic [IDXW-1:0]            wr_addr, rd_addr;
    logic [MEMW-1:0]            wr_data, rd_data;
    split_req_t                 sreq;
    logic                       split;
    logic                       accept, out_free, out_load;
    level_t                     rd_level;
    logic [PHONE_CODE_BITS-1:0] rd_code;
    logic [CNTW-1:0]            cnt_m1;

    // wrap an offset from the head of the circular store
    function automatic logic [IDXW-1:0] phys(input logic [IDXW-1:0] base,
                                             input logic [IDXW-1:0] off);
        logic [IDXW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[IDXW-1:0];
    endfunction

    sssu_cluster_mem #(
        .DEPTH (CLUSTER_DEPTH),
        .WIDTH (MEMW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sssu_split_unit u_split (
        .req   (sreq),
        .split (split)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign rd_level  = rd_data[MEMW-1:PHONE_CODE_BITS];
    assign rd_code   = rd_data[PHONE_CODE_BITS-1:0];
    assign cnt_m1    = count_reg - CNTW'(1);

    always_comb
    begin
        sreq.prev = prev_reg;
        sreq.lvl  = (state_reg == S_WEND) ? LV_VOWEL : rd_level;
    end

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        head_next          = head_reg;
        vowel_seen_next    = vowel_seen_reg;
        start_pending_next = start_pending_reg;
        j_next             = j_reg;
        i_next             = i_reg;
        prev_next          = prev_reg;
        mark_valid_next    = mark_valid_reg;
        mark_idx_next      = mark_idx_reg;
        code_hold_next     = code_hold_reg;
        lvl_hold_next      = lvl_hold_reg;
        wend_hold_next     = wend_hold_reg;
        vstart_hold_next   = vstart_hold_reg;
        res_next           = res_reg;
        out_load           = 1'b0;
        wr_en              = 1'b0;
        wr_addr            = phys(head_reg, count_reg[IDXW-1:0]);
        wr_data            = {in_item.level, PHONE_CODE_BITS'(in_item.phone)};
        rd_en              = 1'b0;
        rd_addr            = phys(head_reg, i_reg[IDXW-1:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    code_hold_next   = PHONE_CODE_BITS'(in_item.phone);
                    lvl_hold_next    = in_item.level;
                    wend_hold_next   = in_item.wend;
                    vstart_hold_next = (in_item.level == LV_VOWEL) && vowel_seen_reg
                                       && (count_reg == '0);
                    i_next           = '0;
                    mark_valid_next  = 1'b0;
                    if (in_item.level == LV_VOWEL)
                    begin
                        if (vowel_seen_reg && count_reg != '0)
                        begin
                            j_next     = cnt_m1[IDXW-1:0];
                            prev_next  = LV_VOWEL;
                            state_next = S_PRIME;
                        end
                        else
                        begin
                            state_next = S_EMIT_RD;
                        end
                    end
                    else if (in_item.wend)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else if (count_reg == CNT_DEPTH)
                    begin
                        state_next = S_OVF_RD;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNTW'(1);
                    end
                end
            end

            S_PRIME:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, j_reg);
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (split)
                begin
                    // mark the phone after this one unless it is the vowel
                    mark_valid_next = (CNTW'(j_reg) + CNTW'(1)) < count_reg;
                    mark_idx_next   = j_reg + IDXW'(1);
                    state_next      = S_EMIT_RD;
                end
                else
                begin
                    prev_next = rd_level;
                    if (j_reg == '0)
                    begin
                        state_next = S_WEND;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = phys(head_reg, j_reg - IDXW'(1));
                        j_next  = j_reg - IDXW'(1);
                    end
                end
            end

            S_WEND:
            begin
                // walk ran past the oldest phone: treat the store start as a vowel
                mark_valid_next = split;
                mark_idx_next   = '0;
                state_next      = S_EMIT_RD;
            end

            S_EMIT_RD:
            begin
                if (i_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_EMIT_OUT;
                end
                else
                begin
                    state_next = S_EMIT_LAST;
                end
            end

            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    res_next.phone     = PHONE_PORT_BITS'(rd_code);
                    res_next.start     = start_pending_reg || (mark_valid_reg
                                         && (CNTW'(mark_idx_reg) == i_reg));
                    res_next.last      = 1'b0;
                    res_next.ovf       = 1'b0;
                    start_pending_next = 1'b0;
                    i_next             = i_reg + CNTW'(1);
                    state_next         = S_EMIT_RD;
                end
            end

            S_EMIT_LAST:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    res_next.phone  = PHONE_PORT_BITS'(code_hold_reg);
                    res_next.start  = start_pending_reg || vstart_hold_reg;
                    res_next.last   = wend_hold_reg;
                    res_next.ovf    = 1'b0;
                    count_next      = '0;
                    state_next      = S_IDLE;
                    if (wend_hold_reg)
                    begin
                        vowel_seen_next    = 1'b0;
                        start_pending_next = 1'b1;
                    end
                    else
                    begin
                        vowel_seen_next    = vowel_seen_reg || (lvl_hold_reg == LV_VOWEL);
                        start_pending_next = 1'b0;
                    end
                end
            end

            S_OVF_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_OVF_OUT;
            end

            S_OVF_OUT:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    res_next.phone     = PHONE_PORT_BITS'(rd_code);
                    res_next.start     = start_pending_reg;
                    res_next.last      = 1'b0;
                    res_next.ovf       = 1'b1;
                    start_pending_next = 1'b0;
                    // the freed oldest slot becomes the newest
                    wr_en              = 1'b1;
                    wr_addr            = head_reg;
                    wr_data            = {lvl_hold_reg, code_hold_reg};
                    head_next          = phys(head_reg, IDXW'(1));
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            head_reg          <= '0;
            vowel_seen_reg    <= 1'b0;
            start_pending_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            head_reg          <= head_next;
            vowel_seen_reg    <= vowel_seen_next;
            start_pending_reg <= start_pending_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg           <= j_next;
        i_reg           <= i_next;
        prev_reg        <= prev_next;
        mark_valid_reg  <= mark_valid_next;
        mark_idx_reg    <= mark_idx_next;
        code_hold_reg   <= code_hold_next;
        lvl_hold_reg    <= lvl_hold_next;
        wend_hold_reg   <= wend_hold_next;
        vstart_hold_reg <= vstart_hold_next;
        res_reg         <= res_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_DEPTH)
        else $error("cluster count beyond store depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_next.ovf) |-> count_reg == CNT_DEPTH)
        else $error("overflow word emitted with store not full");

    a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.level == LV_VOWEL && vowel_seen_reg && count_reg != '0)
        |=> state_reg == S_PRIME)
        else $error("vowel after a cluster did not start the walk");

    a_wend_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LAST && out_free && wend_hold_reg)
        |=> (start_pending_reg && !vowel_seen_reg && count_reg == '0))
        else $error("word end did not restore word state");
`endif

endmodule

// ===== rtl/sonority_syllable_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// sonority_syllable_splitter_unit - sonority-based syllable splitter
// Stream top level: decodes phone features into sonority levels and hands
// items to the cluster sequencer.
// ----------------------------------------------------------------------------
// A consonant that goes into the cluster store is taken while the sequencer
// stays idle; an overflowing consonant reads the oldest stored phone, emits
// it and takes its slot. A vowel or word-end phone drains the buffered
// consonants through the output register after any backward walk, which steps
// one stored phone per cycle through the single shared sonority compare unit;
// the cluster store has one registered read port, read once per emitted
// word, and that sets the drain rate. The block holds s_tready low until an
// item's last word is loaded, and results wait in an output register so the
// input side is free again while the last word is still waiting to be taken.
module sonority_syllable_splitter_unit #(
    parameter int CLUSTER_DEPTH   = sssu_pkg::CLUSTER_DEPTH_DEF,
    parameter int PHONE_CODE_BITS = sssu_pkg::PHONE_CODE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // phone_code
    input  logic [9:0]  s_tuser,   // vocalic, is_plosive, is_nasal, is_lateral,
                                   // is_liquid, is_approximant, is_strident,
                                   // is_alveolar, is_fricative, is_affricate
    input  logic        s_tlast,   // word_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // phone_out
    output logic [1:0]  m_tuser,   // syllable_start, cluster_overflow
    output logic        m_tlast    // last_of_word
);

    import sssu_pkg::*;

    item_t       item;
    res_t        res;
    phone_feat_t feat;

    assign feat       = phone_feat_t'(s_tuser);
    assign item.phone = s_tdata;
    assign item.level = level_of(feat);
    assign item.wend  = s_tlast;

    sssu_seq #(
        .CLUSTER_DEPTH   (CLUSTER_DEPTH),
        .PHONE_CODE_BITS (PHONE_CODE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = res.phone;
    assign m_tuser = {res.ovf, res.start};
    assign m_tlast = res.last;

endmodule

// ===== tb/sv/syllable_mark_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syllable_mark_checker - output predictor and scoreboard for the splitter
// Watches both stream channels. Every accepted phone runs through a sonority
// model of the cluster buffer, and the words it releases are queued. Every
// word taken from the master side is compared against the oldest one queued.
// ----------------------------------------------------------------------------
module syllable_mark_checker #(
    parameter int HELD_DEPTH = sssu_pkg::CLUSTER_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [9:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          words_due
);

    import sssu_pkg::*;

    logic [7:0] held_phone [HELD_DEPTH];
    level_t     held_level [HELD_DEPTH];
    int         held_count;
    bit         vowel_seen;
    bit         start_pending;
    res_t       expected_words [$];
    int         mismatch_total;

    assign mismatches = mismatch_total;

    function automatic level_t sonority_rank(input phone_feat_t f);
        if (f.vocalic)                      return LV_VOWEL;
        if (f.is_plosive)                   return LV_PLOSIVE;
        if (f.is_nasal)                     return LV_NASAL;
        if (f.is_lateral)                   return LV_LATERAL;
        if (f.is_liquid)                    return LV_VIBRANT;
        if (f.is_approximant)               return LV_APPROX;
        if (f.is_strident && f.is_alveolar) return LV_STRIDENT;
        if (f.is_fricative || f.is_affricate)
        begin
            return LV_FRIC;
        end
        return LV_UNKNOWN;
    endfunction

    // cur is the phone stepped onto, prev the one after it in time
    function automatic bit breaks_onset(input level_t cur, input level_t prev);
        if (cur > prev)                                  return 1'b1;
        if (cur == prev && cur != LV_APPROX)             return 1'b1;
        if (cur == LV_PLOSIVE && prev == LV_NASAL)       return 1'b1;
        if (cur == LV_NASAL && prev == LV_STRIDENT)      return 1'b1;
        if (cur == LV_NASAL && prev == LV_LATERAL)       return 1'b1;
        if (cur == LV_LATERAL && prev == LV_STRIDENT)    return 1'b1;
        return 1'b0;
    endfunction

    task automatic queue_word(input logic [7:0] code, input bit start, input bit ovf);
        res_t r;
        r.phone = code;
        r.start = start || start_pending;
        r.last  = 1'b0;
        r.ovf   = ovf;
        start_pending = 1'b0;
        expected_words.push_back(r);
    endtask

    task automatic take_phone(input logic [7:0] code, input phone_feat_t feat,
                              input logic wend);
        level_t lvl;
        level_t prev;
        int     n;
        int     mark;
        int     j;
        bit     done;
        lvl = sonority_rank(feat);
        n   = held_count;
        if (lvl == LV_VOWEL)
        begin
            mark = -1;
            if (vowel_seen && n > 0)
            begin
                // walk back from the vowel until breaks_onset finds a boundary
                prev = LV_VOWEL;
                done = 1'b0;
                j    = n;
                while (j > 0 && !done)
                begin
                    j--;
                    if (breaks_onset(held_level[j], prev))
                    begin
                        if (j + 1 < n)
                        begin
                            mark = j + 1;
                        end
                        done = 1'b1;
                    end
                    prev = held_level[j];
                end
                if (!done && breaks_onset(LV_VOWEL, prev))
                begin
                    mark = 0;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                queue_word(held_phone[i], mark == i, 1'b0);
            end
            queue_word(code, vowel_seen && n == 0, 1'b0);
            held_count = 0;
            vowel_seen = 1'b1;
        end
        else if (wend)
        begin
            for (int i = 0; i < n; i++)
            begin
                queue_word(held_phone[i], 1'b0, 1'b0);
            end
            queue_word(code, 1'b0, 1'b0);
            held_count = 0;
        end
        else
        begin
            if (n >= HELD_DEPTH)
            begin
                // full: push out the oldest and shift down
                queue_word(held_phone[0], 1'b0, 1'b1);
                for (int i = 0; i < HELD_DEPTH - 1; i++)
                begin
                    held_phone[i] = held_phone[i + 1];
                    held_level[i] = held_level[i + 1];
                end
                n = HELD_DEPTH - 1;
            end
            held_phone[n] = code;
            held_level[n] = lvl;
            held_count    = n + 1;
        end
        if (wend)
        begin
            expected_words[$].last = 1'b1;
            held_count    = 0;
            vowel_seen    = 1'b0;
            start_pending = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("[%0t] splitter mismatch: %s", $time, what);
    endtask

    task automatic check_word();
        res_t got;
        res_t want;
        got.phone = m_tdata;
        got.start = m_tuser[0];
        got.ovf   = m_tuser[1];
        got.last  = m_tlast;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word phone=%02h start=%0b last=%0b ovf=%0b",
                                      got.phone, got.start, got.last, got.ovf));
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.phone !== want.phone || got.start !== want.start ||
                got.last !== want.last || got.ovf !== want.ovf)
            begin
                report_mismatch($sformatf(
                    "phone %02h/%02h start %0b/%0b last %0b/%0b ovf %0b/%0b (got/exp)",
                    got.phone, want.phone, got.start, want.start,
                    got.last, want.last, got.ovf, want.ovf));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count    = 0;
            vowel_seen    = 1'b0;
            start_pending = 1'b1;
            expected_words.delete();
            words_due <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_word();
            end
            if (s_tvalid && s_tready)
            begin
                take_phone(s_tdata, phone_feat_t'(s_tuser), s_tlast);
            end
            words_due <= expected_words.size();
        end
    end

    initial
    begin
        mismatch_total = 0;
    end

endmodule

// ===== tb/sv/sonority_syllable_splitter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonority_syllable_splitter_unit_tb - stream testbench for the splitter
// Sends a directed run of words covering every sonority class, three onset
// exception pairs, vowel hiatus, unknown phones, word-end flushes and buffer
// overflow, then random words under several sender and receiver idle mixes.
// A separate checker predicts and scores every output word.
// ----------------------------------------------------------------------------
module sonority_syllable_splitter_unit_tb;
    import sssu_pkg::*;

    typedef enum int {
        PK_VOWEL,
        PK_PLOSIVE,
        PK_NASAL,
        PK_LATERAL,
        PK_VIBRANT,
        PK_APPROX,
        PK_STRIDENT,
        PK_FRIC,
        PK_UNKNOWN
    } phone_kind_e;

    localparam int DIRECTED_LEN   = 28;
    localparam int PHASE_PHONES   = 98;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [9:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int words_pending;
    int phones_sent      = 0;
    int sender_idle_pct  = 0;
    int recv_stall_pct   = 0;

    phone_kind_e directed_kinds [DIRECTED_LEN] = '{
        PK_STRIDENT, PK_VOWEL, PK_VOWEL,
        PK_PLOSIVE, PK_NASAL, PK_VOWEL,
        PK_NASAL, PK_LATERAL, PK_VOWEL,
        PK_LATERAL, PK_STRIDENT, PK_APPROX, PK_VOWEL,
        PK_UNKNOWN, PK_VOWEL,
        PK_FRIC, PK_VIBRANT, PK_PLOSIVE,
        PK_NASAL, PK_FRIC, PK_PLOSIVE, PK_LATERAL, PK_UNKNOWN,
        PK_VIBRANT, PK_APPROX, PK_STRIDENT, PK_NASAL, PK_VOWEL
    };
    // word ends after the plosive coda and at the vowel after the overflow run
    logic [DIRECTED_LEN-1:0] directed_wend = DIRECTED_LEN'((1 << 17) | (1 << 27));

    always #6 clk = ~clk;

    sonority_syllable_splitter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    syllable_mark_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatch_count),
        .words_due  (words_pending)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Random feature bits, then force the class bit and clear the ones that
    // would outrank it, so lower-priority bits still toggle freely.
    function automatic phone_feat_t shape_features(input phone_kind_e kind);
        phone_feat_t f;
        f = phone_feat_t'($urandom_range(1023));
        if (kind == PK_VOWEL)
        begin
            f.vocalic = 1'b1;
            return f;
        end
        f.vocalic = 1'b0;
        if (kind == PK_PLOSIVE)
        begin
            f.is_plosive = 1'b1;
            return f;
        end
        f.is_plosive = 1'b0;
        if (kind == PK_NASAL)
        begin
            f.is_nasal = 1'b1;
            return f;
        end
        f.is_nasal = 1'b0;
        if (kind == PK_LATERAL)
        begin
            f.is_lateral = 1'b1;
            return f;
        end
        f.is_lateral = 1'b0;
        if (kind == PK_VIBRANT)
        begin
            f.is_liquid = 1'b1;
            return f;
        end
        f.is_liquid = 1'b0;
        if (kind == PK_APPROX)
        begin
            f.is_approximant = 1'b1;
            return f;
        end
        f.is_approximant = 1'b0;
        if (kind == PK_STRIDENT)
        begin
            f.is_strident = 1'b1;
            f.is_alveolar = 1'b1;
            return f;
        end
        if ($urandom_range(1))
        begin
            f.is_strident = 1'b0;
        end
        else
        begin
            f.is_alveolar = 1'b0;
        end
        if (kind == PK_FRIC)
        begin
            if (!f.is_fricative && !f.is_affricate)
            begin
                if ($urandom_range(1))
                begin
                    f.is_fricative = 1'b1;
                end
                else
                begin
                    f.is_affricate = 1'b1;
                end
            end
            return f;
        end
        f.is_fricative = 1'b0;
        f.is_affricate = 1'b0;
        return f;
    endfunction

    function automatic phone_kind_e pick_consonant();
        if ($urandom_range(11) == 0)
        begin
            return PK_UNKNOWN;
        end
        return phone_kind_e'($urandom_range(PK_FRIC, PK_PLOSIVE));
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(15);
        if (r == 0)
        begin
            return 8'h00;
        end
        if (r == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_phone(input logic [7:0] code, input phone_feat_t feat,
                              input logic wend);
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= feat;
        s_tlast  <= wend;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        phones_sent++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
            begin
                @(posedge clk);
            end
        end
    endtask

    task automatic send_word();
        phone_kind_e kinds [$];
        logic        ends [$];
        int          syllables;
        int          onset;
        int          coda;
        int          len;
        if ($urandom_range(99) < 85)
        begin
            syllables = $urandom_range(1, 3);
            for (int s = 0; s < syllables; s++)
            begin
                // now and then a long cluster, which may overflow the buffer
                onset = ($urandom_range(19) == 0) ? $urandom_range(7, 11)
                                                  : $urandom_range(0, 3);
                for (int c = 0; c < onset; c++)
                begin
                    kinds.push_back(pick_consonant());
                    ends.push_back(1'b0);
                end
                kinds.push_back(PK_VOWEL);
                ends.push_back(1'b0);
            end
            coda = $urandom_range(0, 2);
            for (int c = 0; c < coda; c++)
            begin
                kinds.push_back(pick_consonant());
                ends.push_back(1'b0);
            end
            ends[$] = 1'b1;
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int c = 0; c < len; c++)
            begin
                kinds.push_back(phone_kind_e'($urandom_range(PK_UNKNOWN, PK_VOWEL)));
                ends.push_back($urandom_range(9) == 0);
            end
        end
        foreach (kinds[k])
        begin
            send_phone(pick_code(), shape_features(kinds[k]), ends[k]);
        end
    endtask

    // hold off the sender until every predicted word has come out
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int d = 0; d < DIRECTED_LEN; d++)
        begin
            send_phone((d == 0) ? 8'h00 : (d == 1) ? 8'hFF : pick_code(),
                       shape_features(directed_kinds[d]), directed_wend[d]);
        end
        drain_outputs();

        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 86;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 86;
                end
                default:
                begin
                    sender_idle_pct = 11;
                    recv_stall_pct  = 11;
                end
            endcase
            while (phones_sent < DIRECTED_LEN + PHASE_PHONES * (ph + 1))
            begin
                send_word();
            end
            drain_outputs();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
        begin
            $display("sonority_syllable_splitter_unit verification clean");
        end
        else
        begin
            $display("sonority_syllable_splitter_unit verification failed");
        end
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("sonority_syllable_splitter_unit verification failed");
        $finish;
    end

endmodule

// ===== sonority_syllable_splitter_unit.f =====
rtl/sssu_pkg.sv
rtl/sssu_cluster_mem.sv
rtl/sssu_split_unit.sv
rtl/sssu_seq.sv
rtl/sonority_syllable_splitter_unit.sv
tb/sv/syllable_mark_checker.sv
tb/sv/sonority_syllable_splitter_unit_tb.sv
